[rtl/trst_pkg.sv]
// Shared constants and types for the tagged response slot table.
package trst_pkg;

    localparam int SLOT_COUNT_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int TAG_W           = 8;
    localparam int PAYLOAD_W       = 16;

    localparam logic FUNC_DELIVER = 1'b0;
    localparam logic FUNC_POP     = 1'b1;

    typedef struct packed {
        logic done;
        logic found;
        logic dropped;
    } rsp_status_t;

endpackage

[rtl/trst_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module trst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/trst_ctrl.sv]
// Slot table control: tag match, slot claim and release, queue pointers and store addressing.
module trst_ctrl
    import trst_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ADDR_W      = ((SLOT_COUNT * QUEUE_DEPTH) > 1) ?
                                $clog2(SLOT_COUNT * QUEUE_DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              func,
    input  logic [TAG_W-1:0]  tag,
    output logic              mem_we,
    output logic [ADDR_W-1:0] mem_addr,
    output rsp_status_t       rsp
);

    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = FILL_W + 1;

    logic [SLOT_COUNT-1:0] valid_reg;
    logic [SLOT_COUNT-1:0] valid_next;
    logic [TAG_W-1:0]      key_reg  [SLOT_COUNT];
    logic [TAG_W-1:0]      key_next [SLOT_COUNT];
    logic [HEAD_W-1:0]     head_reg  [SLOT_COUNT];
    logic [HEAD_W-1:0]     head_next [SLOT_COUNT];
    logic [FILL_W-1:0]     fill_reg  [SLOT_COUNT];
    logic [FILL_W-1:0]     fill_next [SLOT_COUNT];
    rsp_status_t           rsp_reg;
    rsp_status_t           rsp_next;

    logic [SLOT_COUNT-1:0] match;
    logic                  any_match;
    logic                  any_free;
    logic                  any_pop;
    logic [SLOT_W-1:0]     match_idx;
    logic [SLOT_W-1:0]     free_idx;
    logic [SLOT_W-1:0]     pop_idx;
    logic [SUM_W-1:0]      tail_sum;
    logic [HEAD_W-1:0]     tail_pos;
    logic [HEAD_W-1:0]     head_inc;
    logic [SLOT_W-1:0]     sel;
    logic [HEAD_W-1:0]     ofs;

    always_comb
    begin
        any_match = 1'b0;
        any_free  = 1'b0;
        any_pop   = 1'b0;
        match_idx = '0;
        free_idx  = '0;
        pop_idx   = '0;
        for (int s = SLOT_COUNT - 1; s >= 0; s--)
        begin
            match[s] = valid_reg[s] && (key_reg[s] == tag);
            if (match[s])
            begin
                any_match = 1'b1;
                match_idx = SLOT_W'(s);
            end
            if (match[s] && (fill_reg[s] != '0))
            begin
                any_pop = 1'b1;
                pop_idx = SLOT_W'(s);
            end
            if (!valid_reg[s])
            begin
                any_free = 1'b1;
                free_idx = SLOT_W'(s);
            end
        end
    end

    always_comb
    begin
        tail_sum = SUM_W'(head_reg[match_idx]) + SUM_W'(fill_reg[match_idx]);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH))
        begin
            tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
        end
        tail_pos = HEAD_W'(tail_sum);

        if (SUM_W'(head_reg[pop_idx]) == SUM_W'(QUEUE_DEPTH - 1))
        begin
            head_inc = '0;
        end
        else
        begin
            head_inc = head_reg[pop_idx] + HEAD_W'(1);
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        head_next  = head_reg;
        fill_next  = fill_reg;
        rsp_next   = '0;
        sel        = '0;
        ofs        = '0;
        mem_we     = 1'b0;
        if (accept)
        begin
            rsp_next.done = 1'b1;
            if (func == FUNC_DELIVER)
            begin
                if (any_match)
                begin
                    sel = match_idx;
                    if (fill_reg[match_idx] >= FILL_W'(QUEUE_DEPTH))
                    begin
                        rsp_next.dropped = 1'b1;
                    end
                    else
                    begin
                        ofs            = tail_pos;
                        mem_we         = 1'b1;
                        fill_next[sel] = fill_reg[match_idx] + FILL_W'(1);
                    end
                end
                else if (any_free)
                begin
                    sel             = free_idx;
                    mem_we          = 1'b1;
                    valid_next[sel] = 1'b1;
                    key_next[sel]   = tag;
                    head_next[sel]  = '0;
                    fill_next[sel]  = FILL_W'(1);
                end
                else
                begin
                    rsp_next.dropped = 1'b1;
                end
            end
            else if (any_pop)
            begin
                sel            = pop_idx;
                ofs            = head_reg[pop_idx];
                rsp_next.found = 1'b1;
                head_next[sel] = head_inc;
                fill_next[sel] = fill_reg[pop_idx] - FILL_W'(1);
                if (fill_reg[pop_idx] == FILL_W'(1))
                begin
                    valid_next[sel] = 1'b0;
                end
            end
        end
        mem_addr = ADDR_W'(sel) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ofs);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            head_reg  <= '{default: '0};
            fill_reg  <= '{default: '0};
            rsp_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign rsp = rsp_reg;

endmodule

[rtl/tagged_response_slot_table.sv]
// Top level of the tagged response slot table.
// The block takes one command transaction in every clock cycle and busy stays low; each command
// gives exactly one result on the cycle after it is accepted, marked by done, and that result
// must be taken in that cycle because it cannot be held. A pop reads the response memory, whose
// registered read port yields the payload alongside done; payload_out is zero unless found.
module tagged_response_slot_table
    import trst_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 func,
    input  logic [TAG_W-1:0]     tag,
    input  logic [PAYLOAD_W-1:0] payload_in,
    output logic                 done,
    output logic                 found,
    output logic [PAYLOAD_W-1:0] payload_out,
    output logic                 dropped
);

    localparam int STORE_DEPTH = SLOT_COUNT * QUEUE_DEPTH;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic                 accept;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_addr;
    logic [PAYLOAD_W-1:0] mem_rdata;
    rsp_status_t          rsp;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    trst_ctrl #(
        .SLOT_COUNT  (SLOT_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .func     (func),
        .tag      (tag),
        .mem_we   (mem_we),
        .mem_addr (mem_addr),
        .rsp      (rsp)
    );

    trst_ram #(
        .WIDTH (PAYLOAD_W),
        .DEPTH (STORE_DEPTH),
        .AW    (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_addr),
        .wdata (payload_in),
        .raddr (mem_addr),
        .rdata (mem_rdata)
    );

    assign done        = rsp.done;
    assign found       = rsp.found;
    assign dropped     = rsp.dropped;
    assign payload_out = rsp.found ? mem_rdata : '0;

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("Result strobe without an accepted transaction.");

    a_found_and_dropped_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(found && dropped))
        else $error("Result flags both found and dropped.");

    a_deliver_never_found: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_DELIVER) |=> (done && !found))
        else $error("Deliver transaction reported a found response.");

    a_pop_never_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == FUNC_POP) |=> (done && !dropped))
        else $error("Pop transaction reported a dropped response.");

endmodule

[tb/tb_tagged_response_slot_table.sv]
// Self-checking testbench for the tagged response slot table: queued commands, predictor, monitor.
module tb_tagged_response_slot_table;
    import trst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = SLOT_COUNT_DEF;
    localparam int DEPTH       = QUEUE_DEPTH_DEF;
    localparam int RANDOM_CMDS = 1450;
    localparam int TAIL_CMDS   = 150;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic                 func;
        logic [TAG_W-1:0]     tag;
        logic [PAYLOAD_W-1:0] payload;
        bit                   drain_first;
    } command_t;

    typedef struct {
        logic                 found;
        logic [PAYLOAD_W-1:0] payload;
        logic                 dropped;
    } response_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 func = FUNC_DELIVER;
    logic [TAG_W-1:0]     tag = '0;
    logic [PAYLOAD_W-1:0] payload_in = '0;
    logic                 busy;
    logic                 done;
    logic                 found;
    logic [PAYLOAD_W-1:0] payload_out;
    logic                 dropped;

    command_t  command_q[$];
    response_t response_q[$];
    response_t predicted;
    response_t observed;
    response_t wanted;
    command_t  next_cmd;

    logic                 slot_used [SLOTS];
    logic [TAG_W-1:0]     slot_tag  [SLOTS];
    logic [PAYLOAD_W-1:0] slot_store[SLOTS][DEPTH];
    int                   slot_head [SLOTS];
    int                   slot_fill [SLOTS];

    int outstanding = 0;
    int idle_left = 0;
    int cycles = 0;
    int errors = 0;
    int checked = 0;
    int n_deliver = 0;
    int n_dropped = 0;
    int n_pop = 0;
    int n_found = 0;

    tagged_response_slot_table u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .tag         (tag),
        .payload_in  (payload_in),
        .done        (done),
        .found       (found),
        .payload_out (payload_out),
        .dropped     (dropped)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    task automatic table_predict(input logic op, input logic [TAG_W-1:0] key,
                                 input logic [PAYLOAD_W-1:0] data, output response_t rsp);
        int hit;
        int free_slot;
        rsp.found   = 1'b0;
        rsp.payload = '0;
        rsp.dropped = 1'b0;
        hit = -1;
        free_slot = -1;
        if (op == FUNC_DELIVER)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                if (hit < 0 && slot_used[s] && slot_tag[s] == key)
                    hit = s;
                if (free_slot < 0 && !slot_used[s])
                    free_slot = s;
            end
            if (hit < 0 && free_slot >= 0)
            begin
                hit = free_slot;
                slot_used[hit] = 1'b1;
                slot_tag[hit]  = key;
                slot_head[hit] = 0;
                slot_fill[hit] = 0;
            end
            if (hit < 0 || slot_fill[hit] >= DEPTH)
                rsp.dropped = 1'b1;
            else
            begin
                slot_store[hit][(slot_head[hit] + slot_fill[hit]) % DEPTH] = data;
                slot_fill[hit]++;
            end
        end
        else
        begin
            for (int s = 0; s < SLOTS; s++)
                if (hit < 0 && slot_used[s] && slot_tag[s] == key && slot_fill[s] != 0)
                    hit = s;
            if (hit >= 0)
            begin
                rsp.found   = 1'b1;
                rsp.payload = slot_store[hit][slot_head[hit]];
                slot_head[hit] = (slot_head[hit] + 1) % DEPTH;
                slot_fill[hit]--;
                if (slot_fill[hit] == 0)
                    slot_used[hit] = 1'b0;
            end
        end
    endtask

    task automatic add_command(input logic op, input logic [TAG_W-1:0] key,
                               input logic [PAYLOAD_W-1:0] data, input bit drain);
        command_t c;
        c.func        = op;
        c.tag         = key;
        c.payload     = data;
        c.drain_first = drain;
        command_q.insert(command_q.size(), c);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            func       <= FUNC_DELIVER;
            tag        <= '0;
            payload_in <= '0;
            idle_left  <= 0;
            for (int s = 0; s < SLOTS; s++)
            begin
                slot_used[s] = 1'b0;
                slot_tag[s]  = '0;
                slot_head[s] = 0;
                slot_fill[s] = 0;
            end
        end
        else
        begin
            if (done)
                outstanding--;
            if (start && !busy)
            begin
                table_predict(func, tag, payload_in, predicted);
                response_q.insert(response_q.size(), predicted);
                outstanding++;
            end
            if (start && busy)
            begin
            end
            else if (idle_left != 0)
            begin
                start     <= 1'b0;
                idle_left <= idle_left - 1;
            end
            else if (command_q.size() == 0)
                start <= 1'b0;
            else if (command_q[0].drain_first && outstanding != 0)
                start <= 1'b0;
            else if (command_q.size() > TAIL_CMDS && $urandom_range(0, 9) == 0)
            begin
                start     <= 1'b0;
                idle_left <= $urandom_range(0, 15);
            end
            else
            begin
                next_cmd    = command_q.pop_front();
                start      <= 1'b1;
                func       <= next_cmd.func;
                tag        <= next_cmd.tag;
                payload_in <= next_cmd.payload;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            observed.found   = found;
            observed.payload = payload_out;
            observed.dropped = dropped;
            if (response_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("Unexpected result: found=%0b payload_out=%h dropped=%0b",
                             found, payload_out, dropped);
            end
            else
            begin
                wanted = response_q.pop_front();
                checked++;
                if (wanted.dropped || (!wanted.found && wanted.payload == '0 && n_pop < 0))
                    n_dropped++;
                if (observed.found !== wanted.found || observed.payload !== wanted.payload
                    || observed.dropped !== wanted.dropped)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("Mismatch on transaction %0d: expected found=%0b %s%h %s%0b,%s",
                                 checked, wanted.found, "payload_out=", wanted.payload,
                                 "dropped=", wanted.dropped, "");
                    if (errors <= MAX_REPORTS)
                        $display("    got found=%0b payload_out=%h dropped=%0b",
                                 observed.found, observed.payload, observed.dropped);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (start && !busy && rst_n)
        begin
            if (func == FUNC_DELIVER)
                n_deliver++;
            else
                n_pop++;
        end
        if (rst_n && done && found)
            n_found++;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding", cycles,
                     response_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [TAG_W-1:0] tag_pool[10];
        int               deliver_pct;
        int               drain_point;

        add_command(FUNC_POP,     8'h00, 16'h0000, 1'b0);
        add_command(FUNC_DELIVER, 8'h00, 16'h0000, 1'b0);
        add_command(FUNC_DELIVER, 8'hFF, 16'hFFFF, 1'b0);
        add_command(FUNC_DELIVER, 8'hFF, 16'hA5A5, 1'b0);
        add_command(FUNC_DELIVER, 8'hFF, 16'h5A5A, 1'b0);
        add_command(FUNC_DELIVER, 8'hFF, 16'h1234, 1'b0);
        add_command(FUNC_DELIVER, 8'hFF, 16'h4321, 1'b0);
        for (int t = 1; t <= 6; t++)
            add_command(FUNC_DELIVER, t[TAG_W-1:0], 16'h0100 + t[PAYLOAD_W-1:0], 1'b0);
        add_command(FUNC_DELIVER, 8'h07, 16'hC0DE, 1'b0);
        add_command(FUNC_POP,     8'hFF, 16'hFFFF, 1'b0);
        add_command(FUNC_DELIVER, 8'hFF, 16'hBEEF, 1'b0);
        for (int i = 0; i < 4; i++)
            add_command(FUNC_POP, 8'hFF, 16'h0000, 1'b0);
        add_command(FUNC_POP,     8'hFF, 16'h0000, 1'b0);
        add_command(FUNC_DELIVER, 8'h07, 16'h7007, 1'b0);
        add_command(FUNC_POP,     8'h00, 16'h0000, 1'b0);
        add_command(FUNC_POP,     8'h00, 16'h0000, 1'b0);
        add_command(FUNC_POP,     8'h07, 16'h0000, 1'b1);

        drain_point = $urandom_range(200, RANDOM_CMDS - 300);
        deliver_pct = 50;
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            logic [TAG_W-1:0] key;
            logic             op;
            if (i % 50 == 0)
            begin
                for (int p = 0; p < 10; p++)
                    tag_pool[p] = TAG_W'($urandom_range(0, 255));
                case ($urandom_range(0, 2))
                    0: deliver_pct = 80;
                    1: deliver_pct = 25;
                    default: deliver_pct = 50;
                endcase
            end
            if ($urandom_range(0, 99) < 85)
                key = tag_pool[$urandom_range(0, 9)];
            else
                key = TAG_W'($urandom_range(0, 255));
            op = ($urandom_range(0, 99) < deliver_pct) ? FUNC_DELIVER : FUNC_POP;
            add_command(op, key, PAYLOAD_W'($urandom_range(0, 65535)), i == drain_point);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (command_q.size() != 0 || start || outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (response_q.size() != 0)
        begin
            $display("%0d expected results never arrived", response_q.size());
            errors += response_q.size();
        end
        $display("Ran %0d transactions: %0d deliveries, %0d pops of which %0d found a response.",
                 checked, n_deliver, n_pop, n_found);
        $display("Full queues, a full table, empty pops and head wraparound were exercised.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
